FILE: src/convex_polygon_point_test_macros.svh
// Assertion helpers for the point test block.
`ifndef CONVEX_POLYGON_POINT_TEST_MACROS_SVH
`define CONVEX_POLYGON_POINT_TEST_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication, disabled while in reset.
`define CPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: src/cpt_pkg.sv
package cpt_pkg;

  localparam int MaxVertices = 16;
  localparam int CoordBits   = 16;

  localparam logic [1:0] OpClear  = 2'd0;
  localparam logic [1:0] OpAppend = 2'd1;
  localparam logic [1:0] OpQuery  = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusTooFew  = 2'd1;
  localparam logic [1:0] StatusFull    = 2'd2;

endpackage

FILE: src/cpt_in_if.sv
interface cpt_in_if #(
  parameter int CoordBits = cpt_pkg::CoordBits
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic signed [CoordBits-1:0] x_coord;
  logic signed [CoordBits-1:0] y_coord;

  modport source (output valid, operation, x_coord, y_coord, input ready);
  modport sink   (input valid, operation, x_coord, y_coord, output ready);
endinterface

FILE: src/cpt_out_if.sv
interface cpt_out_if;
  logic       valid;
  logic       ready;
  logic       inside_res;
  logic [1:0] status;

  modport source (output valid, inside_res, status, input ready);
  modport sink   (input valid, inside_res, status, output ready);
endinterface

FILE: src/cpt_ram.sv
module cpt_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: src/convex_polygon_point_test.sv
// Clear and append: result registered the cycle after the transfer.
// Query on an ordered table: vertex 0 is read and captured, then each edge is
// read, multiplied and compared in turn through the vertex RAM's single read port.
// First query after loading with ordering on first sorts the vertices by angle.
// Reset (async, active low): empty table, unordered, ordering enabled.
`include "convex_polygon_point_test_macros.svh"

module convex_polygon_point_test #(
  parameter int MAX_VERTICES = cpt_pkg::MaxVertices,
  parameter int COORD_BITS   = cpt_pkg::CoordBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  cpt_in_if.sink          in_i,
  cpt_out_if.source       out_o
);
  localparam int W  = COORD_BITS;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int SW = W + CW;          // centroid sum
  localparam int OW = W + CW + 1;      // count-scaled offset
  localparam int PW = 2 * OW;          // offset cross products
  localparam int QW = 2 * (W + 1);     // edge cross products

  // One-hot sequencer.
  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_SUM_RD = 16'h0002,  // centroid sum pass
    ST_SUM_AC = 16'h0004,
    ST_OI_RD  = 16'h0008,  // fetch the vertex being ranked
    ST_OI_CAP = 16'h0010,
    ST_OJ_RD  = 16'h0020,  // compare against every vertex
    ST_OJ_CAP = 16'h0040,
    ST_OJ_MUL = 16'h0080,
    ST_OJ_CMP = 16'h0100,
    ST_WR     = 16'h0200,  // place vertex at its rank in the other bank
    ST_Q_RD0  = 16'h0400,  // edge walk
    ST_Q_CAP0 = 16'h0800,
    ST_Q_RD   = 16'h1000,
    ST_Q_MUL  = 16'h2000,
    ST_Q_CMP  = 16'h4000,
    ST_RESP   = 16'h8000
  } state_e;

  // Angle class in atan2 order: below axis, +x axis or origin, above, -x axis.
  function automatic logic [1:0] angle_cls(logic signed [OW-1:0] dx,
                                           logic signed [OW-1:0] dy);
    logic [1:0] c;
    if (dy < 0) begin
      c = 2'd0;
    end else if (dy == 0 && dx >= 0) begin
      c = 2'd1;
    end else if (dy > 0) begin
      c = 2'd2;
    end else begin
      c = 2'd3;
    end
    return c;
  endfunction

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d, idx_q, idx_d, i_q, i_d, rank_q, rank_d;
  logic sorted_q, sorted_d, sort_en_q, sort_en_d, bank_q, bank_d;
  logic res_valid_q, res_valid_d, inside_q, inside_d;
  logic [1:0] status_q, status_d;

  logic signed [SW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic signed [OW-1:0] oix_q, oix_d, oiy_q, oiy_d, ojx_q, ojx_d, ojy_q, ojy_d;
  logic [2*W-1:0] vi_q, vi_d, v0_q, v0_d, prev_q, prev_d;
  logic signed [PW-1:0] p1_q, p1_d, p2_q, p2_d;
  logic [1:0] clsi_q, clsi_d, clsj_q, clsj_d;
  logic signed [W-1:0] px_q, px_d, py_q, py_d;
  logic signed [QW-1:0] qp1_q, qp1_d, qp2_q, qp2_d;
  logic fail_q, fail_d, neg_q, neg_d;

  // Vertex RAM: two banks, the ordering pass copies into the idle one.
  logic [AW-1:0]  raddr, waddr;
  logic [2*W-1:0] wdata, rdata0, rdata1, rdata;
  logic           we0, we1, we_act, we_oth;

  cpt_ram #(.Width(2 * W), .Depth(MAX_VERTICES)) u_bank0 (
    .clk_i(clk_i), .we_i(we0), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata0)
  );
  cpt_ram #(.Width(2 * W), .Depth(MAX_VERTICES)) u_bank1 (
    .clk_i(clk_i), .we_i(we1), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata1)
  );

  assign rdata = bank_q ? rdata1 : rdata0;
  assign we0   = bank_q ? we_oth : we_act;
  assign we1   = bank_q ? we_act : we_oth;

  logic signed [W-1:0] rd_x, rd_y;
  assign rd_x = rdata[2*W-1:W];
  assign rd_y = rdata[W-1:0];

  // Offsets scaled by count: n*v - sum, exact and division free.
  logic signed [CW:0]   n_s;
  logic signed [OW-1:0] ofs_x, ofs_y;
  assign n_s   = {1'b0, count_q};
  assign ofs_x = OW'(n_s) * OW'(rd_x) - OW'(sx_q);
  assign ofs_y = OW'(n_s) * OW'(rd_y) - OW'(sy_q);

  logic [CW-1:0] last;
  assign last = count_q - CW'(1);

  // Rank rule: strictly smaller angle, or equal angle and earlier in the table.
  logic less_ji, less_ij;
  assign less_ji = (clsj_q < clsi_q) || (clsj_q == clsi_q && !clsj_q[0] && p1_q > p2_q);
  assign less_ij = (clsi_q < clsj_q) || (clsj_q == clsi_q && !clsi_q[0] && p2_q > p1_q);

  // Edge walk operands.
  logic [2*W-1:0]      nxt;
  logic signed [W-1:0] pv_x, pv_y, nx_x, nx_y;
  assign nxt  = (idx_q == last) ? v0_q : rdata;
  assign pv_x = prev_q[2*W-1:W];
  assign pv_y = prev_q[W-1:0];
  assign nx_x = nxt[2*W-1:W];
  assign nx_y = nxt[W-1:0];

  logic in_xfer, out_free;
  assign out_free    = !res_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == ST_IDLE) && out_free;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign out_o.valid      = res_valid_q;
  assign out_o.inside_res = inside_q;
  assign out_o.status     = status_q;

  always_comb begin
    state_d = state_q;   count_d = count_q;  idx_d = idx_q;   i_d = i_q;
    rank_d = rank_q;     sorted_d = sorted_q; bank_d = bank_q;
    sort_en_d = cfg_we_i ? cfg_wdata_i : sort_en_q;
    res_valid_d = (res_valid_q && out_o.ready) ? 1'b0 : res_valid_q;
    inside_d = inside_q; status_d = status_q;
    sx_d = sx_q; sy_d = sy_q; oix_d = oix_q; oiy_d = oiy_q; ojx_d = ojx_q; ojy_d = ojy_q;
    vi_d = vi_q; v0_d = v0_q; prev_d = prev_q; p1_d = p1_q; p2_d = p2_q;
    clsi_d = clsi_q; clsj_d = clsj_q; px_d = px_q; py_d = py_q;
    qp1_d = qp1_q; qp2_d = qp2_q; fail_d = fail_q; neg_d = neg_q;
    raddr = idx_q[AW-1:0];
    waddr = count_q[AW-1:0];
    wdata = {in_i.x_coord, in_i.y_coord};
    we_act = 1'b0;
    we_oth = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          px_d = in_i.x_coord;
          py_d = in_i.y_coord;
          case (in_i.operation)
            cpt_pkg::OpClear: begin
              count_d = '0;
              sorted_d = 1'b0;
              res_valid_d = 1'b1; inside_d = 1'b0; status_d = cpt_pkg::StatusOk;
            end
            cpt_pkg::OpAppend: begin
              res_valid_d = 1'b1; inside_d = 1'b0;
              if (count_q < CW'(MAX_VERTICES)) begin
                we_act = 1'b1;
                count_d = count_q + CW'(1);
                sorted_d = 1'b0;
                status_d = cpt_pkg::StatusOk;
              end else begin
                status_d = cpt_pkg::StatusFull;
              end
            end
            cpt_pkg::OpQuery: begin
              if (count_q < CW'(3)) begin
                res_valid_d = 1'b1; inside_d = 1'b0; status_d = cpt_pkg::StatusTooFew;
              end else if (sort_en_q && !sorted_q) begin
                sx_d = '0; sy_d = '0; idx_d = '0;
                state_d = ST_SUM_RD;
              end else begin
                state_d = ST_Q_RD0;
              end
            end
            default: begin
              res_valid_d = 1'b1; inside_d = 1'b0; status_d = cpt_pkg::StatusOk;
            end
          endcase
        end
      end
      ST_SUM_RD: state_d = ST_SUM_AC;
      ST_SUM_AC: begin
        sx_d = sx_q + SW'(rd_x);
        sy_d = sy_q + SW'(rd_y);
        idx_d = idx_q + CW'(1);
        if (idx_q == last) begin
          i_d = '0;
          state_d = ST_OI_RD;
        end else begin
          state_d = ST_SUM_RD;
        end
      end
      ST_OI_RD: begin
        raddr = i_q[AW-1:0];
        state_d = ST_OI_CAP;
      end
      ST_OI_CAP: begin
        vi_d = rdata;
        oix_d = ofs_x;
        oiy_d = ofs_y;
        rank_d = '0;
        idx_d = '0;
        state_d = ST_OJ_RD;
      end
      ST_OJ_RD: state_d = ST_OJ_CAP;
      ST_OJ_CAP: begin
        ojx_d = ofs_x;
        ojy_d = ofs_y;
        state_d = ST_OJ_MUL;
      end
      ST_OJ_MUL: begin
        p1_d = PW'(ojx_q) * PW'(oiy_q);
        p2_d = PW'(ojy_q) * PW'(oix_q);
        clsi_d = angle_cls(oix_q, oiy_q);
        clsj_d = angle_cls(ojx_q, ojy_q);
        state_d = ST_OJ_CMP;
      end
      ST_OJ_CMP: begin
        if (less_ji || (!less_ij && idx_q < i_q)) begin
          rank_d = rank_q + CW'(1);
        end
        idx_d = idx_q + CW'(1);
        state_d = (idx_q == last) ? ST_WR : ST_OJ_RD;
      end
      ST_WR: begin
        waddr = rank_q[AW-1:0];
        wdata = vi_q;
        we_oth = 1'b1;
        i_d = i_q + CW'(1);
        if (i_q == last) begin
          bank_d = !bank_q;
          sorted_d = 1'b1;
          state_d = ST_Q_RD0;
        end else begin
          state_d = ST_OI_RD;
        end
      end
      ST_Q_RD0: begin
        raddr = '0;
        state_d = ST_Q_CAP0;
      end
      ST_Q_CAP0: begin
        v0_d = rdata;
        prev_d = rdata;
        idx_d = '0;
        fail_d = 1'b0;
        state_d = ST_Q_RD;
      end
      ST_Q_RD: begin
        raddr = idx_q[AW-1:0] + AW'(1);
        state_d = ST_Q_MUL;
      end
      ST_Q_MUL: begin
        qp1_d = QW'(QW'(nx_x) - QW'(pv_x)) * QW'(QW'(py_q) - QW'(pv_y));
        qp2_d = QW'(QW'(nx_y) - QW'(pv_y)) * QW'(QW'(px_q) - QW'(pv_x));
        prev_d = nxt;
        state_d = ST_Q_CMP;
      end
      ST_Q_CMP: begin
        if (qp1_q == qp2_q) begin
          fail_d = 1'b1;
        end else if (idx_q == '0) begin
          neg_d = qp1_q < qp2_q;
        end else if ((qp1_q < qp2_q) != neg_q) begin
          fail_d = 1'b1;
        end
        idx_d = idx_q + CW'(1);
        state_d = (idx_q == last) ? ST_RESP : ST_Q_RD;
      end
      ST_RESP: begin
        if (out_free) begin
          res_valid_d = 1'b1;
          inside_d = !fail_q;
          status_d = cpt_pkg::StatusOk;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      sorted_q    <= 1'b0;
      sort_en_q   <= 1'b1;
      bank_q      <= 1'b0;
      res_valid_q <= 1'b0;
      idx_q       <= '0;
      i_q         <= '0;
      rank_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sorted_q    <= sorted_d;
      sort_en_q   <= sort_en_d;
      bank_q      <= bank_d;
      res_valid_q <= res_valid_d;
      idx_q       <= idx_d;
      i_q         <= i_d;
      rank_q      <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inside_q <= inside_d;  status_q <= status_d;
    sx_q <= sx_d;   sy_q <= sy_d;
    oix_q <= oix_d; oiy_q <= oiy_d; ojx_q <= ojx_d; ojy_q <= ojy_d;
    vi_q <= vi_d;   v0_q <= v0_d;   prev_q <= prev_d;
    p1_q <= p1_d;   p2_q <= p2_d;   clsi_q <= clsi_d; clsj_q <= clsj_d;
    px_q <= px_d;   py_q <= py_d;   qp1_q <= qp1_d;   qp2_q <= qp2_d;
    fail_q <= fail_d; neg_q <= neg_d;
  end

  // Checks
  `CPT_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_i.ready, state_q == ST_IDLE)
  `CPT_ASSERT_IMP(a_count_max, clk_i, rst_ni, 1'b1, count_q <= CW'(MAX_VERTICES))
  `CPT_ASSERT_NEXT(a_append_count, clk_i, rst_ni,
    in_xfer && in_i.operation == cpt_pkg::OpAppend && count_q < CW'(MAX_VERTICES),
    count_q == $past(count_q) + CW'(1))
  `CPT_ASSERT_NEXT(a_resp_out, clk_i, rst_ni, state_q == ST_RESP && out_free,
    res_valid_q && state_q == ST_IDLE)

endmodule
